@@ sv/tbd_pkg.sv @@
// Shared types and constants for the timed button debouncer.
`default_nettype none

package tbd_pkg;

  // Button phases
  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_BOUNCE   = 3'd1,
    PH_PRESSED  = 3'd2,
    PH_BOUNCE2  = 3'd3,
    PH_RELEASED = 3'd4
  } phase_e;

  // Register word indexes (byte address = 4 * index)
  localparam int unsigned RegIdxW = 3;
  localparam logic [RegIdxW-1:0] REG_SOURCE_MODE  = 3'd0;
  localparam logic [RegIdxW-1:0] REG_ACTIVE_LEVEL = 3'd1;
  localparam logic [RegIdxW-1:0] REG_DEBOUNCE_MS  = 3'd2;
  localparam logic [RegIdxW-1:0] REG_TARGET_VALUE = 3'd3;
  localparam logic [RegIdxW-1:0] REG_TOLERANCE    = 3'd4;

  // Field widths
  localparam int unsigned TimeW   = 32;
  localparam int unsigned DebW    = 16;
  localparam int unsigned SampleW = 10;
  localparam int unsigned AddrW   = 5;
  localparam int unsigned DataW   = 32;

  // Register reset values
  localparam logic [DebW-1:0]    DEBOUNCE_RST  = 16'd5;
  localparam logic [SampleW-1:0] TOLERANCE_RST = 10'd10;

endpackage : tbd_pkg

`default_nettype wire

@@ sv/timed_button_debouncer.sv @@
// Top level of the timed button debouncer: input stage, phase machine, result stage.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-----------------------------------------------
//  input    | in_valid_i / in_stall_o | now_ms_i, raw_level_i, analog_sample_i, report_on_i
//  result   | out_valid_o/ out_stall_i| event_res_o
//  config   | APB psel/penable/pwrite | paddr (5b), pwdata/prdata (32b), pready = 1
//
// One item per cycle while the result side is not stalled: a transfer is registered in the
// input stage (in_vld_q), evaluated there, and its result registered in the result stage
// (out_vld_q), which drives out_valid_o.
// The phase update (one 32-bit subtract and compare) sets the cycle time.
// Reset clears the phase to idle, the stamp to zero and registers to defaults.
// A stalled result holds; the input stalls only when both stages are full.
`default_nettype none

module timed_button_debouncer
  import tbd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // input channel
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [TimeW-1:0]   now_ms_i,
  input  wire logic               raw_level_i,
  input  wire logic [SampleW-1:0] analog_sample_i,
  input  wire logic               report_on_i,
  // result channel
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    event_res_o,
  // configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [AddrW-1:0]   paddr,
  input  wire logic [DataW-1:0]   pwdata,
  output logic [DataW-1:0]        prdata,
  output logic                    pready
);

  // Configuration registers
  logic               source_mode_q;
  logic               active_level_q;
  logic [DebW-1:0]    debounce_ms_q;
  logic [SampleW-1:0] target_value_q;
  logic [SampleW-1:0] tolerance_q;

  logic               cfg_wr;
  logic [RegIdxW-1:0] cfg_idx;

  // Pipeline registers
  logic               in_vld_q;
  logic [TimeW-1:0]   now_q;
  logic               level_q;
  logic [SampleW-1:0] sample_q;
  logic               want_rel_q;
  logic               out_vld_q;
  logic               event_q;

  // Phase machine state
  phase_e             phase_q, phase_d;
  logic [TimeW-1:0]   stamp_q, stamp_d;

  logic               out_free;
  logic               advance;
  logic               in_xfer;
  logic               act;
  logic               settled;
  logic [TimeW-1:0]   elapsed;
  logic [SampleW:0]   win_lo_sum;
  logic [SampleW:0]   win_hi;
  logic               event_d;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[AddrW-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      source_mode_q  <= 1'b0;
      active_level_q <= 1'b0;
      debounce_ms_q  <= DEBOUNCE_RST;
      target_value_q <= '0;
      tolerance_q    <= TOLERANCE_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SOURCE_MODE:  source_mode_q  <= pwdata[0];
        REG_ACTIVE_LEVEL: active_level_q <= pwdata[0];
        REG_DEBOUNCE_MS:  debounce_ms_q  <= pwdata[DebW-1:0];
        REG_TARGET_VALUE: target_value_q <= pwdata[SampleW-1:0];
        REG_TOLERANCE:    tolerance_q    <= pwdata[SampleW-1:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    prdata = '0;
    case (cfg_idx)
      REG_SOURCE_MODE:  prdata[0]           = source_mode_q;
      REG_ACTIVE_LEVEL: prdata[0]           = active_level_q;
      REG_DEBOUNCE_MS:  prdata[DebW-1:0]    = debounce_ms_q;
      REG_TARGET_VALUE: prdata[SampleW-1:0] = target_value_q;
      REG_TOLERANCE:    prdata[SampleW-1:0] = tolerance_q;
      default:          prdata              = '0;
    endcase
  end

  // Handshake: result stage frees up when empty or being taken
  assign out_free   = !out_vld_q || !out_stall_i;
  assign advance    = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // Input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_xfer) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      now_q      <= now_ms_i;
      level_q    <= raw_level_i;
      sample_q   <= analog_sample_i;
      want_rel_q <= report_on_i;
    end
  end

  // Active test; window is target-tol < s < target+tol, rewritten without a signed lower bound
  assign win_lo_sum = {1'b0, sample_q} + {1'b0, tolerance_q};
  assign win_hi     = {1'b0, target_value_q} + {1'b0, tolerance_q};
  always_comb begin
    if (source_mode_q) begin
      act = (win_lo_sum > {1'b0, target_value_q}) && ({1'b0, sample_q} < win_hi);
    end else begin
      act = (level_q == active_level_q);
    end
  end

  // Wrapping elapsed time against the debounce window
  assign elapsed = now_q - stamp_q;
  assign settled = !(elapsed < {{(TimeW-DebW){1'b0}}, debounce_ms_q});

  // Next phase and stamp
  always_comb begin
    phase_d = phase_q;
    stamp_d = stamp_q;
    case (phase_q)
      PH_IDLE: begin
        if (act) begin
          phase_d = PH_BOUNCE;
          stamp_d = now_q;
        end
      end
      PH_BOUNCE: begin
        if (!act) begin
          phase_d = PH_IDLE;
        end else if (settled) begin
          phase_d = PH_PRESSED;
        end
      end
      PH_PRESSED: begin
        if (!act) begin
          phase_d = PH_BOUNCE2;
          stamp_d = now_q;
        end
      end
      PH_BOUNCE2: begin
        if (act) begin
          phase_d = PH_PRESSED;
        end else if (settled) begin
          phase_d = PH_RELEASED;
        end
      end
      PH_RELEASED: begin
        if (!act) begin
          phase_d = PH_IDLE;
        end
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  // Event output (want_rel_q selects which is reported): press on entering pressed, release on every step in released
  always_comb begin
    case (phase_q)
      PH_BOUNCE:   event_d = act && settled && !want_rel_q;
      PH_RELEASED: event_d = want_rel_q;
      default:     event_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      stamp_q <= '0;
    end else if (advance) begin
      phase_q <= phase_d;
      stamp_q <= stamp_d;
    end
  end

  // Result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= advance;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      event_q <= event_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign event_res_o = event_q;

endmodule : timed_button_debouncer

`default_nettype wire

@@ sv/tbd_checker.sv @@
// Port-level checks for the timed button debouncer, bound to the top level.
`default_nettype none

module tbd_checker
  import tbd_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_stall_o,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire logic event_res_o
);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(event_res_o))
    else $error("result changed while stalled");

  // Input backpressure only when the result side is blocked
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while result side free");

  // A fresh result follows an input transfer through the input and result stages
  a_rose_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without a matching input transfer");

  // An input transfer while the result stage is empty produces a result
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_valid_o |=> ##1 out_valid_o)
    else $error("result missing after input transfer");

endmodule : tbd_checker

bind timed_button_debouncer tbd_checker u_tbd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .event_res_o (event_res_o)
);

`default_nettype wire
